// File: hw/rtl/dcbf_pkg.sv
// Shared types and constants for the DC-blocking filter with block RMS.
// Holds the controller/datapath command and status structs and fixed widths.
// No dependencies.
package dcbf_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int ALPHA_W    = 16;
  localparam int FV_W       = 30;
  localparam int ACC_W      = 31;
  localparam int PROD_W     = 48;
  localparam int F_W        = 18;
  localparam int SQ_W       = 36;
  localparam int SUM_W      = 43;
  localparam int RMS_W      = 17;
  localparam int RAD_W      = 44;
  localparam int ROOT_W     = 22;
  localparam int ITER_W     = 5;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 40;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd65274;
  localparam logic signed [31:0] Y_MAX = 32'sd536870911;
  localparam logic signed [31:0] Y_MIN = -32'sd536870912;
  localparam logic [RMS_W-1:0]   RMS_MAX = 17'h1FFFF;

  typedef struct packed {
    logic load;
    logic mul;
    logic round;
    logic scale;
    logic square;
    logic acc;
    logic out_load;
  } dcbf_cmd_t;

  typedef struct packed {
    logic in_ignore;
    logic block_end;
    logic root_busy;
    logic out_free;
  } dcbf_status_t;

endpackage

// File: hw/rtl/dcbf_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Uses dcbf_pkg for the radicand and root widths.
module dcbf_isqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dcbf_pkg::RAD_W-1:0] radicand,
  output logic                       busy,
  output logic [dcbf_pkg::ROOT_W-1:0] root
);
  import dcbf_pkg::*;

  logic [RAD_W-1:0]    rad;
  logic [ROOT_W+1:0]   rem;
  logic [ITER_W-1:0]   iter;
  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+1:0]   trial;
  logic                fits;

  assign rem_sh = {rem[ROOT_W-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= ITER_W'(ROOT_W - 1);
    end else if (busy) begin
      iter <= iter - 1'b1;
      if (iter == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// File: hw/rtl/dcbf_datapath.sv
// Datapath: per-channel filter state, the two multiply steps, the square
// accumulators, the square root unit and the output register.
// Depends on dcbf_pkg and dcbf_isqrt.
module dcbf_datapath #(
  parameter int BLOCK_LEN = 256,
  parameter int CHANNELS  = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dcbf_pkg::dcbf_cmd_t            cmd,
  output dcbf_pkg::dcbf_status_t         status,
  input  logic                           s_tuser,
  input  logic [dcbf_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           cfg_valid,
  input  logic [dcbf_pkg::ALPHA_W-1:0]   cfg_data,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dcbf_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tuser,
  output logic                           m_tlast
);
  import dcbf_pkg::*;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W      = $clog2(BLOCK_LEN);
  localparam int MEAN_SHIFT = $clog2(BLOCK_LEN + 1) - 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_LEN - 1);

  logic [ALPHA_W-1:0]         alpha;
  logic signed [FV_W-1:0]     fv   [CHANNELS];
  logic [SAMPLE_W-1:0]        prev [CHANNELS];
  logic [SUM_W-1:0]           sum  [CHANNELS];
  logic [CNT_W-1:0]           cnt  [CHANNELS];

  logic [CH_W-1:0]            in_idx;
  logic [SAMPLE_W-1:0]        in_x;
  logic signed [SAMPLE_W:0]   in_d;
  logic signed [ACC_W-1:0]    in_s;

  logic [CH_W-1:0]            ch;
  logic                       ch_bit;
  logic [SAMPLE_W-1:0]        x;
  logic signed [ACC_W-1:0]    s_acc;
  logic signed [PROD_W-1:0]   prod;
  logic signed [FV_W-1:0]     y;
  logic signed [F_W-1:0]      f;
  logic [SQ_W-1:0]            sq;
  logic                       done;

  logic signed [PROD_W-1:0]   prod_rnd;
  logic signed [31:0]         y_full;
  logic signed [FV_W-1:0]     y_next;
  logic signed [FV_W:0]       y_rnd;
  logic signed [F_W:0]        f_full;
  logic signed [F_W-1:0]      f_next;
  logic [F_W-1:0]             mag;
  logic [SUM_W:0]             sum_add;
  logic [SUM_W-1:0]           sum_sat;
  logic [RAD_W-1:0]           rad;
  logic                       root_start;
  logic                       root_busy;
  logic [ROOT_W-1:0]          root;
  logic [RMS_W-1:0]           rms_sat;

  logic                       out_valid;
  logic                       out_ch;
  logic signed [F_W-1:0]      out_f;
  logic                       out_done;
  logic [RMS_W-1:0]           out_rms;

  assign in_idx = CH_W'(s_tuser);
  assign in_x   = s_tdata[SAMPLE_W-1:0];
  assign in_d   = $signed({1'b0, in_x}) - $signed({1'b0, prev[in_idx]});
  assign in_s   = $signed({fv[in_idx][FV_W-1], fv[in_idx]})
                + $signed({{(ACC_W-SAMPLE_W-17){in_d[SAMPLE_W]}}, in_d, 16'b0});

  assign prod_rnd = prod + PROD_W'(32768);
  assign y_full   = prod_rnd[PROD_W-1:16];

  always_comb begin
    if (y_full > Y_MAX) begin
      y_next = FV_W'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_next = FV_W'(Y_MIN);
    end else begin
      y_next = y_full[FV_W-1:0];
    end
  end

  assign y_rnd  = $signed({y[FV_W-1], y}) + (FV_W+1)'(2048);
  assign f_full = y_rnd[FV_W:12];

  always_comb begin
    if (f_full[F_W] != f_full[F_W-1]) begin
      f_next = f_full[F_W] ? {1'b1, {(F_W-1){1'b0}}} : {1'b0, {(F_W-1){1'b1}}};
    end else begin
      f_next = f_full[F_W-1:0];
    end
  end

  assign mag     = f[F_W-1] ? (~f + 1'b1) : f;
  assign sum_add = {1'b0, sum[ch]} + (SUM_W+1)'(sq);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign rad     = RAD_W'(sum_sat >> MEAN_SHIFT);
  assign rms_sat = (root > ROOT_W'(RMS_MAX)) ? RMS_MAX : root[RMS_W-1:0];

  assign root_start = cmd.acc && (cnt[ch] == CNT_LAST);

  dcbf_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (rad),
    .busy     (root_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RESET;
    end else if (cfg_valid) begin
      alpha <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        fv[i]   <= '0;
        prev[i] <= '0;
        sum[i]  <= '0;
        cnt[i]  <= '0;
      end
    end else begin
      if (cmd.round) begin
        fv[ch]   <= y_next;
        prev[ch] <= x;
      end
      if (cmd.acc) begin
        if (cnt[ch] == CNT_LAST) begin
          sum[ch] <= '0;
          cnt[ch] <= '0;
        end else begin
          sum[ch] <= sum_sat;
          cnt[ch] <= cnt[ch] + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch     <= in_idx;
      ch_bit <= s_tuser;
      x      <= in_x;
      s_acc  <= in_s;
    end
    if (cmd.mul) begin
      prod <= $signed({1'b0, alpha}) * s_acc;
    end
    if (cmd.round) begin
      y <= y_next;
    end
    if (cmd.scale) begin
      f <= f_next;
    end
    if (cmd.square) begin
      sq <= SQ_W'(mag * mag);
    end
    if (cmd.acc) begin
      done <= (cnt[ch] == CNT_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ch   <= ch_bit;
      out_f    <= f;
      out_done <= done;
      out_rms  <= done ? rms_sat : '0;
    end
  end

  assign status.in_ignore = (32'(s_tuser) >= CHANNELS);
  assign status.block_end = (cnt[ch] == CNT_LAST);
  assign status.root_busy = root_busy;
  assign status.out_free  = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ch;
  assign m_tlast  = out_done;
  assign m_tdata  = {{(M_TDATA_W-F_W-RMS_W){1'b0}}, out_rms, out_f};

endmodule

// File: hw/rtl/dcbf_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
// Depends on dcbf_pkg for the command and status structs.
module dcbf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  dcbf_pkg::dcbf_status_t status,
  output dcbf_pkg::dcbf_cmd_t    cmd
);
  import dcbf_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_SCALE  = 3'd3;
  localparam logic [2:0] ST_SQUARE = 3'd4;
  localparam logic [2:0] ST_ACC    = 3'd5;
  localparam logic [2:0] ST_SQRT   = 3'd6;
  localparam logic [2:0] ST_OUT    = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && !status.in_ignore) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round  = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.block_end ? ST_SQRT : ST_OUT;
      end
      ST_SQRT: begin
        if (!status.root_busy) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/dc_block_filter_rms.sv
// Top level of the two-channel DC-blocking high-pass filter with block RMS.
// Depends on dcbf_pkg, dcbf_ctrl and dcbf_datapath.
//
// Channel   Direction  Fields
// s_axis    in         s_tuser: channel; s_tdata[11:0]: sample
// m_axis    out        m_tuser: out_channel; m_tlast: block_done;
//                      m_tdata[17:0]: filtered, m_tdata[34:18]: rms
// cfg       in         cfg_data: alpha (Q0.16)
//
// A sample goes from request to result register through an accept step and
// six steps of the controller: filter multiply, rounding, scaling, square,
// accumulate and output load. The sample that closes a block also waits for the
// bit-serial square root. One sample is in flight at a time; a stalled output
// holds the controller in its final step. Reset is synchronous and clears all
// channel state and sets alpha to 0.996.
module dc_block_filter_rms #(
  parameter int BLOCK_LEN = 256,
  parameter int CHANNELS  = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dcbf_pkg::S_TDATA_W-1:0] s_tdata,  // [11:0] sample, [15:12] zero
  input  logic                           s_tuser,  // [0] channel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dcbf_pkg::M_TDATA_W-1:0] m_tdata,  // [17:0] filtered, [34:18] rms
  output logic                           m_tuser,  // [0] out_channel
  output logic                           m_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dcbf_pkg::ALPHA_W-1:0]   cfg_data
);
  import dcbf_pkg::*;

  dcbf_cmd_t    cmd;
  dcbf_status_t status;

  assign cfg_ready = 1'b1;

  dcbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  dcbf_datapath #(
    .BLOCK_LEN (BLOCK_LEN),
    .CHANNELS  (CHANNELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// File: hw/rtl/dcbf_checker.sv
// Port-level checker for dc_block_filter_rms, attached by the bind below.
// Depends on dcbf_pkg.
module dcbf_checker #(
  parameter int CHANNELS = 2
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [dcbf_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);
  import dcbf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (32'(s_tuser) < CHANNELS)) |=> !s_tready)
    else $error("second request taken while a sample is in flight");

  a_rms_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tdata[F_W+RMS_W-1:F_W] == '0))
    else $error("rms nonzero on a result that does not end a block");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:F_W+RMS_W] == '0))
    else $error("padding bits of result data not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind dc_block_filter_rms dcbf_checker #(.CHANNELS(CHANNELS)) u_dcbf_checker (.*);

// File: bench/testbench.sv
// Self-checking bench for the two-channel DC-blocking filter with block RMS.
// Drives samples and coefficient writes, predicts every result and checks it.
// Depends on dcbf_pkg and dc_block_filter_rms.
module testbench;
  import dcbf_pkg::*;

  localparam int BLOCK_LEN     = 256;
  localparam int CHANNELS      = 2;
  localparam int MEAN_SHIFT    = $clog2(BLOCK_LEN + 1) - 1;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 205;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AT       = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam longint Y_HI      = 64'sd536870911;
  localparam longint Y_LO      = -64'sd536870912;
  localparam longint F_HI      = 64'sd131071;
  localparam longint F_LO      = -64'sd131072;
  localparam longint SUM_LIMIT = (64'sd1 <<< 43) - 1;
  localparam longint RMS_LIMIT = 64'sd131071;

  typedef enum {ROW_SAMPLE, ROW_ALPHA} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    bit                ch;
    logic [11:0]       x;
    logic [ALPHA_W-1:0] coef;
    bit                known;
  } stim_row_t;

  typedef struct packed {
    logic              ch;
    logic signed [17:0] filtered;
    logic              done;
    logic [16:0]       rms;
  } hp_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [ALPHA_W-1:0]   cfg_data;

  logic [ALPHA_W-1:0] coef_model;
  longint             hp_state [CHANNELS];
  logic [11:0]        last_sample [CHANNELS];
  longint             energy_sum [CHANNELS];
  int                 block_fill [CHANNELS];

  hp_result_t pending_results [$];
  stim_row_t  plan [$];
  int         error_count;
  int         results_seen;
  int         cycle_count;
  bit         tx_steady;

  dc_block_filter_rms #(
    .BLOCK_LEN(BLOCK_LEN),
    .CHANNELS (CHANNELS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic hp_result_t predict_sample(bit ch, logic [11:0] x);
    hp_result_t r;
    longint     diff;
    longint     acc;
    longint     y;
    longint     f;
    longint     rem;
    longint     root;
    longint     probe;
    diff = longint'(x) - longint'(last_sample[ch]);
    acc = hp_state[ch] + diff * 64'sd65536;
    y = (longint'(coef_model) * acc + 64'sd32768) >>> 16;
    if (y > Y_HI) y = Y_HI;
    if (y < Y_LO) y = Y_LO;
    hp_state[ch] = y;
    last_sample[ch] = x;
    f = (y + 64'sd2048) >>> 12;
    if (f > F_HI) f = F_HI;
    if (f < F_LO) f = F_LO;
    energy_sum[ch] = energy_sum[ch] + f * f;
    if (energy_sum[ch] > SUM_LIMIT) energy_sum[ch] = SUM_LIMIT;
    block_fill[ch]++;
    r.ch = ch;
    r.filtered = f[17:0];
    r.done = 1'b0;
    r.rms = '0;
    if (block_fill[ch] >= BLOCK_LEN) begin
      rem = energy_sum[ch] >> MEAN_SHIFT;
      root = 0;
      probe = 64'sd1 <<< 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
        if (rem >= root + probe) begin
          rem = rem - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      if (root > RMS_LIMIT) root = RMS_LIMIT;
      r.done = 1'b1;
      r.rms = root[16:0];
      energy_sum[ch] = 0;
      block_fill[ch] = 0;
    end
    return r;
  endfunction

  function automatic stim_row_t sample_row(bit ch, logic [11:0] x);
    stim_row_t r;
    r.kind = ROW_SAMPLE;
    r.ch = ch;
    r.x = x;
    r.coef = '0;
    r.known = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t zero_row(bit ch, logic [11:0] x);
    stim_row_t r;
    r = sample_row(ch, x);
    r.known = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t alpha_row(logic [ALPHA_W-1:0] v);
    stim_row_t r;
    r = sample_row(1'b0, 12'd0);
    r.kind = ROW_ALPHA;
    r.coef = v;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, results_seen, got, want);
    error_count++;
  endtask

  task automatic send_sample(bit ch, logic [11:0] x, bit known);
    int         gap;
    hp_result_t r;
    gap = tx_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= ch;
    s_tdata <= {{(S_TDATA_W - 12){1'b0}}, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_sample(ch, x);
    if (known) begin
      r.filtered = 18'sd0;
      r.done = 1'b0;
      r.rms = 17'd0;
    end
    pending_results.push_back(r);
  endtask

  task automatic hold_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_alpha(logic [ALPHA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    coef_model = v;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic logic [11:0] draw_sample(bit ch);
    int mode;
    int v;
    mode = $urandom_range(0, 9);
    if (mode <= 3) begin
      v = $urandom_range(0, 4095);
    end else if (mode == 4) begin
      case ($urandom_range(0, 4))
        0: v = 0;
        1: v = 4095;
        2: v = 1;
        3: v = 4094;
        default: v = 2048;
      endcase
    end else if (mode <= 7) begin
      v = int'(last_sample[ch]) + int'($urandom_range(0, 64)) - 32;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
    end else begin
      v = $urandom_range(0, 1) ? 3500 : 500;
    end
    return v[11:0];
  endfunction

  initial begin
    int         gap;
    bit         rx_steady;
    hp_result_t want;
    hp_result_t got;
    m_tready = 1'b0;
    error_count = 0;
    results_seen = 0;
    @(negedge rst);
    forever begin
      rx_steady = ((results_seen / 150) % 3 == 1);
      gap = rx_steady ? 0 : $urandom_range(0, 10);
      if (results_seen == HOLD_AT) gap = LONG_HOLD;
      if (gap > 0) begin
        @(negedge clk) m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got.ch = m_tuser;
      got.filtered = m_tdata[17:0];
      got.done = m_tlast;
      got.rms = m_tdata[34:18];
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request pending", longint'(m_tdata), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.ch !== want.ch) flag_mismatch("out_channel", got.ch, want.ch);
        if (got.filtered !== want.filtered)
          flag_mismatch("filtered", longint'(got.filtered), longint'(want.filtered));
        if (got.done !== want.done) flag_mismatch("block_done", got.done, want.done);
        if (got.rms !== want.rms) flag_mismatch("rms", got.rms, want.rms);
      end
      results_seen++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    logic [ALPHA_W-1:0] phase_coef;
    bit                 ch;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    tx_steady = 1'b0;
    coef_model = ALPHA_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      hp_state[c] = 0;
      last_sample[c] = '0;
      energy_sum[c] = 0;
      block_fill[c] = 0;
    end

    // Zero samples after reset and any sample at alpha zero give all-zero results.
    plan.push_back(zero_row(1'b0, 12'd0));
    plan.push_back(zero_row(1'b1, 12'd0));
    plan.push_back(sample_row(1'b0, 12'd4095));
    plan.push_back(sample_row(1'b0, 12'd0));
    plan.push_back(sample_row(1'b1, 12'd4095));
    plan.push_back(sample_row(1'b1, 12'd4095));
    plan.push_back(sample_row(1'b0, 12'd2048));
    plan.push_back(alpha_row(16'd0));
    plan.push_back(zero_row(1'b0, 12'd4095));
    plan.push_back(zero_row(1'b1, 12'd0));
    plan.push_back(zero_row(1'b0, 12'd0));
    plan.push_back(alpha_row(16'hFFFF));
    plan.push_back(sample_row(1'b0, 12'd4095));
    plan.push_back(sample_row(1'b0, 12'd4095));
    plan.push_back(sample_row(1'b0, 12'd0));
    plan.push_back(sample_row(1'b1, 12'd4095));
    plan.push_back(sample_row(1'b1, 12'd1));
    plan.push_back(sample_row(1'b0, 12'hAAA));
    plan.push_back(sample_row(1'b0, 12'h555));
    plan.push_back(alpha_row(16'd1));
    plan.push_back(sample_row(1'b0, 12'd4095));
    plan.push_back(sample_row(1'b1, 12'd0));
    plan.push_back(alpha_row(ALPHA_RESET));

    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_ALPHA) begin
        hold_idle();
        write_alpha(plan[i].coef);
      end else begin
        send_sample(plan[i].ch, plan[i].x, plan[i].known);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_coef = 16'hFFFF;
        1: phase_coef = 16'd0;
        2: phase_coef = ALPHA_W'($urandom_range(0, 65535));
        3: phase_coef = ALPHA_RESET;
        4: phase_coef = 16'h8000;
        5: phase_coef = ALPHA_W'($urandom_range(64000, 65535));
        default: phase_coef = ALPHA_W'($urandom_range(0, 65535));
      endcase
      hold_idle();
      write_alpha(phase_coef);
      tx_steady = (p == 2) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 3 && i == 100) hold_idle();
        ch = 1'($urandom_range(0, 1));
        send_sample(ch, draw_sample(ch), 1'b0);
      end
    end

    hold_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: dc_block_filter_rms.f
hw/rtl/dcbf_pkg.sv
hw/rtl/dcbf_isqrt.sv
hw/rtl/dcbf_datapath.sv
hw/rtl/dcbf_ctrl.sv
hw/rtl/dc_block_filter_rms.sv
hw/rtl/dcbf_checker.sv
bench/testbench.sv
